FILE: rtl/drc_pkg.sv
// ---------------------------------------------------------------------------
// drc_pkg
// Shared constants, register indexes and a table function of the dynamic
// range compressor / expander.
// ---------------------------------------------------------------------------
package drc_pkg;

    localparam int SMP_W = 24;
    localparam int GR_W  = 16;
    localparam int LVL_W = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MUL_W = 33;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYPASS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAKEUP    = 3'd6;

    localparam logic signed [16:0] FLOOR_DB    = -17'sd15360;
    localparam logic [32:0]        AVG_STEP    = 33'd1678;
    localparam logic [32:0]        DB_PER_LOG2 = 33'd197283;
    localparam logic [32:0]        LOG2_PER_DB = 33'd2786635;

    // 2^(2^(k-16)) in Q1.30, by repeated integer square roots
    function automatic logic [30:0] root_val(input int k);
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bv;
        r = 64'd1 << 31;
        for (int i = 0; i < 16 - k; i++) begin
            x   = r << 30;
            res = '0;
            bv  = 64'd1 << 62;
            for (int j = 0; j < 32; j++) begin
                if (x >= res + bv) begin
                    x   = x - (res + bv);
                    res = (res >> 1) + bv;
                end else begin
                    res = res >> 1;
                end
                bv = bv >> 2;
            end
            r = res;
        end
        return r[30:0];
    endfunction

endpackage

FILE: rtl/drc_in_if.sv
// ---------------------------------------------------------------------------
// drc_in_if
// Input channel: one stereo frame per item.
// ---------------------------------------------------------------------------
interface drc_in_if import drc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] sample_left;
    logic signed [SMP_W-1:0] sample_right;

    modport source(output valid, sample_left, sample_right, input ready);
    modport sink(input valid, sample_left, sample_right, output ready);
endinterface

FILE: rtl/drc_out_if.sv
// ---------------------------------------------------------------------------
// drc_out_if
// Output channel: scaled stereo frame and gain reduction per item.
// ---------------------------------------------------------------------------
interface drc_out_if import drc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] out_left;
    logic signed [SMP_W-1:0] out_right;
    logic signed [GR_W-1:0]  gain_reduction_db;

    modport source(output valid, out_left, out_right, gain_reduction_db, input ready);
    modport sink(input valid, out_left, out_right, gain_reduction_db, output ready);
endinterface

FILE: rtl/drc_mul.sv
// ---------------------------------------------------------------------------
// drc_mul
// Shared signed multiplier used by the multiplying steps of the sequencer.
// ---------------------------------------------------------------------------
module drc_mul import drc_pkg::*; (
    input  logic signed [MUL_W-1:0]   i_a,
    input  logic signed [MUL_W-1:0]   i_b,
    output logic signed [2*MUL_W-1:0] o_p
);
    assign o_p = i_a * i_b;
endmodule

FILE: rtl/dynamic_range_compressor_expander.sv
// ---------------------------------------------------------------------------
// dynamic_range_compressor_expander
// Feed-forward log-domain compressor / expander for stereo frames.
//
// i_item carries one stereo frame (Q1.23) per item, o_item returns the two
// scaled samples and the smoothed gain reduction (Q8.8). The user must write
// registers through i_cfg_we / i_cfg_idx / i_cfg_data only while the block is
// idle; the block itself does not enforce it. One shared multiplier is stepped
// by a sequencer: square, level averaging (expander mode only), leading-one
// search, 16 log2 squaring steps, gain computer (24 restoring divide steps at
// or above threshold in compressor mode), smoothing, exponent, 16 mantissa
// steps and two sample scalings. The search, log2 and divide loops set an
// item's length. i_item.ready is high only in idle. Results sit in an output
// register; when the receiver stalls the finished frame waits there and the
// next item can already be taken and processed. Reset restores register
// defaults and clears level and reduction state.
// ---------------------------------------------------------------------------
module dynamic_range_compressor_expander import drc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    drc_in_if.sink                i_item,
    drc_out_if.source             o_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_SQ, S_AVG_D, S_AVG_HI, S_AVG_LO, S_NORM, S_LOG, S_DB, S_GAIN,
        S_DIV, S_DIVE, S_SMOOTH, S_EXPO, S_MANT, S_OUT_L, S_OUT_R, S_DONE
    } t_state;

    t_state r_state;

    logic               r_mode, r_bypass;
    logic signed [14:0] r_thr;
    logic [14:0]        r_ratio;
    logic [15:0]        r_att, r_rel;
    logic signed [13:0] r_makeup;

    logic [LVL_W-1:0]   r_lvl, r_nrm, r_d;
    logic               r_up;
    logic signed [15:0] r_sred, r_xl;
    logic signed [SMP_W-1:0] r_l, r_r, r_ol, r_or;
    logic [33:0]        r_acc;
    logic [5:0]         r_z;
    logic [4:0]         r_cnt;
    logic [30:0]        r_m, r_mant;
    logic [15:0]        r_frac, r_f;
    logic signed [16:0] r_xg;
    logic [23:0]        r_num;
    logic [15:0]        r_rem;
    logic signed [9:0]  r_n;

    logic               r_ovalid;
    logic signed [SMP_W-1:0] r_out_l, r_out_r;
    logic signed [15:0] r_out_gr;

    logic signed [MUL_W-1:0]   w_ma, w_mb;
    logic signed [2*MUL_W-1:0] w_mp;
    logic [30:0] w_root [16];

    logic signed [24:0] w_sum, w_half;
    logic signed [23:0] w_mono;
    logic [23:0]        w_amono;
    logic signed [16:0] w_t;
    logic [14:0]        w_rt;
    logic [31:0]        w_sqm;
    logic signed [7:0]  w_e;
    logic signed [47:0] w_db;
    logic signed [33:0] w_xle, w_xlc;
    logic [15:0]        w_rs;
    logic signed [16:0] w_diff;
    logic [15:0]        w_a;
    logic signed [40:0] w_sm;
    logic signed [24:0] w_yl;
    logic signed [17:0] w_g;
    logic signed [41:0] w_p;
    logic signed [SMP_W-1:0] w_x;
    logic [23:0]        w_ax;
    logic signed [9:0]  w_nc;
    logic signed [10:0] w_s;
    logic [56:0]        w_rnd, w_mag;
    logic signed [SMP_W-1:0] w_scaled;
    logic [47:0]        w_step;
    logic               w_take;

    genvar gk;
    generate
        for (gk = 0; gk < 16; gk++) begin : g_root
            assign w_root[gk] = root_val(gk);
        end
    endgenerate

    drc_mul u_mul (.i_a(w_ma), .i_b(w_mb), .o_p(w_mp));

    function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
        if (v > 34'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -34'sd32768) begin
            return -16'sh8000;
        end
        return v[15:0];
    endfunction

    always_comb begin
        w_sum   = 25'(r_l) + 25'(r_r);
        w_half  = (w_sum + {24'b0, w_sum[24]}) >>> 1;
        w_mono  = w_half[23:0];
        w_amono = w_mono[23] ? 24'(-w_mono) : w_mono;
        w_t     = 17'(r_thr);
        w_rt    = (r_ratio < 15'd256) ? 15'd256 : r_ratio;
        w_sqm   = w_mp[61:30];
        w_e     = 8'sd1 - $signed({2'b0, r_z});
        w_db    = $signed(w_mp[47:0] + 48'd8388608) >>> 24;
        w_xle   = 34'(r_xg) - 34'(w_t) + $signed({3'b0, w_mp[38:8]});
        w_xlc   = 34'(r_xg) - 34'(w_t) - $signed({10'b0, r_num});
        w_rs    = {r_rem[14:0], r_num[23]};
        w_diff  = 17'(r_sred) - 17'(r_xl);
        w_a     = (r_mode ? (r_xl < r_sred) : (r_xl > r_sred)) ? r_att : r_rel;
        w_sm    = (w_mp[40:0] + 41'sd32768) >>> 16;
        w_yl    = 25'(r_xl) + w_sm[24:0];
        w_g     = 18'(r_makeup) - 18'(r_sred);
        w_p     = (w_mp[41:0] + 42'sd32768) >>> 16;
        w_x     = (r_state == S_OUT_L) ? r_l : r_r;
        w_ax    = w_x[23] ? 24'(-w_x) : w_x;
        w_nc    = (r_n > 10'sd30) ? 10'sd30 : r_n;
        w_s     = 11'sd30 - 11'(w_nc);
        w_rnd   = (w_s == 11'sd0) ? '0 : (57'd1 << (w_s[5:0] - 6'd1));
        w_mag   = (w_s > 11'sd55) ? '0 : ((w_mp[56:0] + w_rnd) >> w_s[5:0]);
        if (w_x[23]) begin
            w_scaled = (w_mag > 57'h800000) ? -24'sh800000 : 24'(-$signed(w_mag[24:0]));
        end else begin
            w_scaled = (w_mag > 57'h7FFFFF) ? 24'sh7FFFFF : w_mag[23:0];
        end
        w_step  = 48'(r_acc) + 48'(w_mp[47:24]);
        w_take  = !r_ovalid || o_item.ready;

        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_SQ: begin
                w_ma = {9'b0, w_amono};
                w_mb = {9'b0, w_amono};
            end
            S_AVG_HI: begin
                w_ma = {9'b0, r_d[47:24]};
                w_mb = AVG_STEP;
            end
            S_AVG_LO: begin
                w_ma = {9'b0, r_d[23:0]};
                w_mb = AVG_STEP;
            end
            S_LOG: begin
                w_ma = {2'b0, r_m};
                w_mb = {2'b0, r_m};
            end
            S_DB: begin
                w_ma = 33'($signed({w_e, r_frac}));
                w_mb = DB_PER_LOG2;
            end
            S_GAIN: begin
                w_ma = 33'(w_t - r_xg);
                w_mb = {18'b0, w_rt};
            end
            S_SMOOTH: begin
                w_ma = {17'b0, w_a};
                w_mb = 33'(w_diff);
            end
            S_EXPO: begin
                w_ma = 33'(w_g);
                w_mb = LOG2_PER_DB;
            end
            S_MANT: begin
                w_ma = {2'b0, r_mant};
                w_mb = {2'b0, w_root[r_cnt[3:0]]};
            end
            S_OUT_L, S_OUT_R: begin
                w_ma = {9'b0, w_ax};
                w_mb = {2'b0, r_mant};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign i_item.ready           = (r_state == S_IDLE);
    assign o_item.valid           = r_ovalid;
    assign o_item.out_left        = r_out_l;
    assign o_item.out_right       = r_out_r;
    assign o_item.gain_reduction_db = r_out_gr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= 1'b0;
            r_bypass <= 1'b0;
            r_thr    <= -15'sd6144;
            r_ratio  <= 15'd12800;
            r_att    <= 16'd64855;
            r_rel    <= 16'd65531;
            r_makeup <= '0;
            r_lvl    <= '0;
            r_sred   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE:      r_mode   <= i_cfg_data[0];
                    CFG_BYPASS:    r_bypass <= i_cfg_data[0];
                    CFG_THRESHOLD: r_thr    <= i_cfg_data[14:0];
                    CFG_RATIO:     r_ratio  <= i_cfg_data[14:0];
                    CFG_ATTACK:    r_att    <= i_cfg_data;
                    CFG_RELEASE:   r_rel    <= i_cfg_data;
                    CFG_MAKEUP:    r_makeup <= i_cfg_data[13:0];
                    default: begin
                    end
                endcase
            end

            if (r_ovalid && o_item.ready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_item.valid) begin
                        r_l <= i_item.sample_left;
                        r_r <= i_item.sample_right;
                        if (r_bypass) begin
                            r_ol    <= i_item.sample_left;
                            r_or    <= i_item.sample_right;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SQ;
                        end
                    end
                end
                S_SQ: begin
                    r_z <= '0;
                    if (r_mode) begin
                        r_nrm   <= w_mp[47:0];
                        r_state <= S_AVG_D;
                    end else begin
                        r_lvl   <= w_mp[47:0];
                        r_nrm   <= w_mp[47:0];
                        r_state <= S_NORM;
                    end
                end
                S_AVG_D: begin
                    r_up    <= (r_nrm >= r_lvl);
                    r_d     <= (r_nrm >= r_lvl) ? (r_nrm - r_lvl) : (r_lvl - r_nrm);
                    r_state <= S_AVG_HI;
                end
                S_AVG_HI: begin
                    r_acc   <= w_mp[33:0];
                    r_state <= S_AVG_LO;
                end
                S_AVG_LO: begin
                    r_lvl   <= r_up ? (r_lvl + w_step) : (r_lvl - w_step);
                    r_nrm   <= r_up ? (r_lvl + w_step) : (r_lvl - w_step);
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    if (r_nrm == '0) begin
                        r_xg    <= FLOOR_DB;
                        r_state <= S_GAIN;
                    end else if (r_nrm[47:32] == '0) begin
                        r_nrm <= r_nrm << 16;
                        r_z   <= r_z + 6'd16;
                    end else if (r_nrm[47:44] == '0) begin
                        r_nrm <= r_nrm << 4;
                        r_z   <= r_z + 6'd4;
                    end else if (!r_nrm[47]) begin
                        r_nrm <= r_nrm << 1;
                        r_z   <= r_z + 6'd1;
                    end else begin
                        r_m     <= r_nrm[47:17];
                        r_frac  <= '0;
                        r_cnt   <= '0;
                        r_state <= S_LOG;
                    end
                end
                S_LOG: begin
                    r_frac <= {r_frac[14:0], w_sqm[31]};
                    r_m    <= w_sqm[31] ? w_sqm[31:1] : w_sqm[30:0];
                    r_cnt  <= r_cnt + 5'd1;
                    if (r_cnt == 5'd15) begin
                        r_state <= S_DB;
                    end
                end
                S_DB: begin
                    r_xg    <= (w_db < 48'(FLOOR_DB)) ? FLOOR_DB : w_db[16:0];
                    r_state <= S_GAIN;
                end
                S_GAIN: begin
                    if (r_mode) begin
                        r_xl    <= (r_xg > w_t) ? 16'sd0 : sat16(w_xle);
                        r_state <= S_SMOOTH;
                    end else if (r_xg < w_t) begin
                        r_xl    <= '0;
                        r_state <= S_SMOOTH;
                    end else begin
                        r_num   <= {16'(r_xg - w_t), 8'b0};
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_rs >= {1'b0, w_rt}) begin
                        r_rem <= w_rs - {1'b0, w_rt};
                        r_num <= {r_num[22:0], 1'b1};
                    end else begin
                        r_rem <= w_rs;
                        r_num <= {r_num[22:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd23) begin
                        r_state <= S_DIVE;
                    end
                end
                S_DIVE: begin
                    r_xl    <= sat16(w_xlc);
                    r_state <= S_SMOOTH;
                end
                S_SMOOTH: begin
                    r_sred  <= w_yl[15:0];
                    r_state <= S_EXPO;
                end
                S_EXPO: begin
                    r_n     <= w_p[25:16];
                    r_f     <= w_p[15:0];
                    r_mant  <= 31'd1 << 30;
                    r_cnt   <= 5'd15;
                    r_state <= S_MANT;
                end
                S_MANT: begin
                    if (r_f[r_cnt[3:0]]) begin
                        r_mant <= 31'((w_mp[61:0] + 62'd536870912) >> 30);
                    end
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd0) begin
                        r_state <= S_OUT_L;
                    end
                end
                S_OUT_L: begin
                    r_ol    <= w_scaled;
                    r_state <= S_OUT_R;
                end
                S_OUT_R: begin
                    r_or    <= w_scaled;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_take) begin
                        r_out_l  <= r_ol;
                        r_out_r  <= r_or;
                        r_out_gr <= r_sred;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: verif/dynamic_range_compressor_expander_tb.sv
// ---------------------------------------------------------------------------
// dynamic_range_compressor_expander_tb
// Self-checking testbench: a queue-fed driver offers stereo frames in random
// bursts, a monitor stalls on its own pattern and checks every output item
// against a bit-exact fixed-point predictor of the compressor / expander.
// Registers are rewritten between phases while the block is drained.
// ---------------------------------------------------------------------------
module dynamic_range_compressor_expander_tb;
    import drc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic [SMP_W-1:0] l;
        logic [SMP_W-1:0] r;
    } t_frame;

    typedef struct packed {
        logic [SMP_W-1:0] l;
        logic [SMP_W-1:0] r;
        logic [GR_W-1:0]  gr;
    } t_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    drc_in_if  in_ch ();
    drc_out_if out_ch ();

    dynamic_range_compressor_expander i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (in_ch.sink),
        .o_item     (out_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    t_frame  pending_frames[$];
    t_result expected_results[$];
    int      err_cnt = 0;
    bit      holdoff_req = 0;

    // register copies and filter state
    bit          cfg_exp, cfg_byp;
    logic [14:0] cfg_thr, cfg_ratio;
    logic [15:0] cfg_att, cfg_rel;
    logic [13:0] cfg_mk;
    longint unsigned level_avg;
    longint          gr_state;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res, bv;
        res = 0;
        bv = 64'd1 << 62;
        while (bv > x) bv = bv >> 2;
        while (bv != 0) begin
            if (x >= res + bv) begin
                x = x - (res + bv);
                res = (res >> 1) + bv;
            end else begin
                res = res >> 1;
            end
            bv = bv >> 2;
        end
        return res;
    endfunction

    function automatic longint level_db(longint unsigned lv);
        int e;
        longint unsigned m;
        longint frac, l2;
        e = 63;
        frac = 0;
        while (lv[e] == 1'b0) e--;
        m = (e > 30) ? (lv >> (e - 30)) : (lv << (30 - e));
        for (int k = 0; k < 16; k++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        l2 = longint'(e - 46) * 65536 + frac;
        return (l2 * 197283 + (64'sd1 <<< 23)) >>> 24;
    endfunction

    function automatic logic [SMP_W-1:0] apply_gain(longint x, longint unsigned mant,
                                                    longint n);
        longint s, rv;
        longint unsigned mag;
        longint hi;
        hi = (64'sd1 <<< 23) - 1;
        if (n > 30) n = 30;
        s = 30 - n;
        mag = longint'(x < 0 ? -x : x) * mant;
        if (s >= 62) mag = 0;
        else if (s > 0) mag = (mag + (64'd1 << (s - 1))) >> s;
        if (x < 0) rv = (mag > longint'(hi) + 1) ? -hi - 1 : -longint'(mag);
        else       rv = (mag > hi) ? hi : longint'(mag);
        return rv[SMP_W-1:0];
    endfunction

    function automatic t_result predict_frame(t_frame f);
        t_result res;
        longint l, r, mono, t, rt, xg, yg, xl, yl, a, g, p, n, fr;
        longint unsigned sq, d, mant, root;
        logic signed [SMP_W-1:0] sl, sr;
        logic signed [14:0] st;
        logic signed [13:0] sm;
        sl = f.l;
        sr = f.r;
        l = sl;
        r = sr;
        if (cfg_byp) begin
            res.l = f.l;
            res.r = f.r;
            res.gr = gr_state[15:0];
            return res;
        end
        mono = (l + r) / 2;
        sq = longint'(mono < 0 ? -mono : mono);
        sq = sq * sq;
        if (cfg_exp) begin
            if (sq >= level_avg) begin
                d = sq - level_avg;
                level_avg = level_avg + (d >> 24) * 1678 + (((d & 64'hFFFFFF) * 1678) >> 24);
            end else begin
                d = level_avg - sq;
                level_avg = level_avg - (d >> 24) * 1678 - (((d & 64'hFFFFFF) * 1678) >> 24);
            end
        end else begin
            level_avg = sq;
        end
        xg = (level_avg == 0) ? -15360 : level_db(level_avg);
        if (xg < -15360) xg = -15360;
        st = cfg_thr;
        t = st;
        rt = cfg_ratio;
        if (rt < 256) rt = 256;
        if (cfg_exp) yg = (xg > t) ? xg : t - ((t - xg) * rt) / 256;
        else         yg = (xg < t) ? xg : t + ((xg - t) * 256) / rt;
        xl = xg - yg;
        if (xl > 32767) xl = 32767;
        if (xl < -32768) xl = -32768;
        if (cfg_exp ? (xl < gr_state) : (xl > gr_state)) a = cfg_att;
        else a = cfg_rel;
        yl = (a * gr_state + (65536 - a) * xl + 32768) >>> 16;
        gr_state = yl;
        sm = cfg_mk;
        g = longint'(sm) - yl;
        p = (g * 2786635 + 32768) >>> 16;
        n = p >>> 16;
        fr = p - n * 65536;
        mant = 64'd1 << 30;
        root = 64'd1 << 31;
        for (int k = 15; k >= 0; k--) begin
            root = int_sqrt(root << 30);
            if (fr[k]) mant = (mant * root + (64'd1 << 29)) >> 30;
        end
        res.l = apply_gain(l, mant, n);
        res.r = apply_gain(r, mant, n);
        res.gr = yl[15:0];
        return res;
    endfunction

    // driver: bursts of random length, random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.sample_left <= '0;
            in_ch.sample_right <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_results.push_back(predict_frame(pending_frames.pop_front()));
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_frames.size() > 0 && gap_left == 0) begin
                    in_ch.valid <= 1'b1;
                    in_ch.sample_left <= pending_frames[0].l;
                    in_ch.sample_right <= pending_frames[0].r;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
                    end
                end else begin
                    in_ch.valid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end
            end
        end
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        err_cnt++;
    endtask

    // monitor: own stall pattern plus one long hold-off on request
    int rx_mode = 0;
    int rx_mode_left = 0;
    int holdoff_left = 0;

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $display("unexpected output item");
                    err_cnt++;
                end else begin
                    want = expected_results.pop_front();
                    if (out_ch.out_left !== want.l)
                        report_mismatch("out_left", 32'(out_ch.out_left), 32'(want.l));
                    if (out_ch.out_right !== want.r)
                        report_mismatch("out_right", 32'(out_ch.out_right), 32'(want.r));
                    if (out_ch.gain_reduction_db !== want.gr)
                        report_mismatch("gain_reduction_db", 32'(out_ch.gain_reduction_db),
                                        32'(want.gr));
                end
            end
            if (holdoff_req) begin
                holdoff_req = 0;
                holdoff_left = 600;
            end
            if (rx_mode_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(5, 200);
            end else begin
                rx_mode_left--;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                out_ch.ready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= $urandom_range(0, 1);
                    2: out_ch.ready <= ($urandom_range(0, 9) == 0);
                    default: out_ch.ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // watchdog
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("dynamic_range_compressor_expander_tb: FAIL");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_MODE:      cfg_exp = val[0];
            CFG_BYPASS:    cfg_byp = val[0];
            CFG_THRESHOLD: cfg_thr = val[14:0];
            CFG_RATIO:     cfg_ratio = val[14:0];
            CFG_ATTACK:    cfg_att = val;
            CFG_RELEASE:   cfg_rel = val;
            CFG_MAKEUP:    cfg_mk = val[13:0];
            default: ;
        endcase
    endtask

    task automatic load_regs(bit md, bit byp, logic [14:0] thr, logic [14:0] rat,
                             logic [15:0] att, logic [15:0] rel, logic [13:0] mk);
        write_reg(CFG_MODE, {15'd0, md});
        write_reg(CFG_BYPASS, {15'd0, byp});
        write_reg(CFG_THRESHOLD, {1'b0, thr});
        write_reg(CFG_RATIO, {1'b0, rat});
        write_reg(CFG_ATTACK, att);
        write_reg(CFG_RELEASE, rel);
        write_reg(CFG_MAKEUP, {2'b0, mk});
        if ($urandom_range(0, 2) == 0) write_reg(CFG_UNUSED, 16'($urandom));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_frames.size() > 0 || in_ch.valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic queue_frame(logic [SMP_W-1:0] l, logic [SMP_W-1:0] r);
        t_frame f;
        f.l = l;
        f.r = r;
        pending_frames.push_back(f);
    endtask

    function automatic logic [SMP_W-1:0] rand_sample();
        logic [SMP_W-1:0] v;
        case ($urandom_range(0, 4))
            0, 1: v = SMP_W'($urandom);
            2: begin
                v = SMP_W'($urandom >> $urandom_range(8, 31));
                if ($urandom_range(0, 1)) v = -v;
            end
            3: v = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            default: v = SMP_W'($urandom_range(0, 3)) - 24'd1;
        endcase
        return v;
    endfunction

    function automatic logic [14:0] rand_thr();
        case ($urandom_range(0, 4))
            0: return 15'(-15360);
            1: return 15'd0;
            2: return 15'($urandom);
            default: return 15'(-int'($urandom_range(0, 15360)));
        endcase
    endfunction

    function automatic logic [14:0] rand_ratio();
        case ($urandom_range(0, 4))
            0: return 15'd256;
            1: return 15'd25600;
            2: return 15'($urandom_range(0, 255));
            3: return 15'($urandom);
            default: return 15'($urandom_range(256, 25600));
        endcase
    endfunction

    function automatic logic [15:0] rand_coeff();
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(60000, 65535));
        endcase
    endfunction

    function automatic logic [13:0] rand_makeup();
        case ($urandom_range(0, 4))
            0: return 14'(-6144);
            1: return 14'd6144;
            2: return 14'($urandom);
            default: return 14'($urandom_range(0, 12288) - 6144);
        endcase
    endfunction

    initial begin
        logic [SMP_W-1:0] s;
        int n_items;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        cfg_exp = 0;
        cfg_byp = 0;
        cfg_thr = 15'(-6144);
        cfg_ratio = 15'd12800;
        cfg_att = 16'd64855;
        cfg_rel = 16'd65531;
        cfg_mk = 14'd0;
        level_avg = 0;
        gr_state = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset defaults: field extremes
        queue_frame(24'h7FFFFF, 24'h7FFFFF);
        queue_frame(24'h800000, 24'h800000);
        queue_frame(24'h7FFFFF, 24'h800000);
        queue_frame(24'h000000, 24'h000000);
        queue_frame(24'h800000, 24'h7FFFFF);
        queue_frame(24'h000001, 24'h000000);
        queue_frame(24'hFFFFFF, 24'hFFFFFF);
        queue_frame(24'h400000, 24'hC00000);
        queue_frame(24'h123456, 24'h654321);
        wait_drained();

        // bypass holds the reduction
        load_regs(0, 1, 15'(-6144), 15'd12800, 16'd64855, 16'd65531, 14'd0);
        queue_frame(24'h7FFFFF, 24'h800000);
        queue_frame(24'h000000, 24'h5A5A5A);
        wait_drained();

        // ratio below one, zero coefficients, expander extremes
        load_regs(0, 0, 15'(-15360), 15'd0, 16'd0, 16'd0, 14'd6144);
        queue_frame(24'h7FFFFF, 24'h7FFFFF);
        queue_frame(24'h001000, 24'h001000);
        queue_frame(24'h000000, 24'h000000);
        wait_drained();
        load_regs(1, 0, 15'd0, 15'd25600, 16'hFFFF, 16'd0, 14'(-6144));
        queue_frame(24'h000010, 24'hFFFFF0);
        queue_frame(24'h7FFFFF, 24'h7FFFFF);
        queue_frame(24'h000100, 24'h000100);
        wait_drained();

        for (int ph = 0; ph < 12; ph++) begin
            load_regs($urandom_range(0, 1), $urandom_range(0, 5) == 0, rand_thr(),
                      rand_ratio(), rand_coeff(), rand_coeff(), rand_makeup());
            @(negedge i_clk);
            if (ph == 3) holdoff_req = 1;
            n_items = $urandom_range(120, 200);
            for (int i = 0; i < n_items; i++) begin
                if ($urandom_range(0, 3) == 0) begin
                    s = rand_sample();
                    queue_frame(s, -s);
                end else if ($urandom_range(0, 3) == 0) begin
                    s = rand_sample();
                    queue_frame(s, s + SMP_W'($urandom_range(0, 255)));
                end else begin
                    queue_frame(rand_sample(), rand_sample());
                end
            end
            wait_drained();
        end

        if (err_cnt == 0 && expected_results.size() == 0) begin
            $display("dynamic_range_compressor_expander_tb: PASS");
        end else begin
            $display("dynamic_range_compressor_expander_tb: FAIL");
        end
        $finish;
    end

endmodule
